FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tremolo RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, masked while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Constants, register indexes and sequencer states of the stereo tremolo.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned SAMPLE_RATE     = 44100;
  localparam int unsigned WRAP_SECONDS    = 8;
  localparam int unsigned SINE_TABLE_BITS = 10;

  // sample counter runs modulo WRAP_SECONDS seconds of samples
  localparam int unsigned WRAP_COUNT = WRAP_SECONDS * SAMPLE_RATE;
  localparam int unsigned COUNT_W    = 19;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned DATA_W   = 32;

  // polynomial sine coefficients, Q15
  localparam logic [16:0] SIN_A = 17'd51472;
  localparam logic [16:0] SIN_B = 17'd21024;
  localparam logic [16:0] SIN_C = 17'd2320;

  localparam logic [DEPTH_W-1:0] DEPTH_FULL  = 16'd32768;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd16384;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd97392;
  localparam logic [OFFS_W-1:0]  OFFS_RESET  = 16'd0;

  localparam int unsigned REG_COUNT = 3;
  localparam int unsigned CFG_IDX_W = $clog2(REG_COUNT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH        = 0,
    REG_PHASE_STEP   = 1,
    REG_RIGHT_OFFSET = 2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CX2,
    ST_T1,
    ST_SIN,
    ST_DEP,
    ST_GAIN,
    ST_RND
  } state_t;

endpackage

FILE: rtl/sst_ifs.sv
// ----------------------------------------------------------------------------
// sst channel interfaces
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface sst_in_if import sst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sst_out_if import sst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sst_cfg_if import sst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/stereo_sine_tremolo.sv
// ----------------------------------------------------------------------------
// stereo_sine_tremolo
// Sine LFO tremolo on a stereo pair, one shared 18x18 multiplier.
// ----------------------------------------------------------------------------
//  channel   role    word
//  samples   sink    left_in, right_in (signed Q1.15)
//  results   source  left_out, right_out (signed Q1.15, saturated)
//  cfg       sink    index, data (depth, phase_step, right_phase_offset)
//
//  A stereo pair is taken only in the idle state. Each channel, left first,
//  gets six passes of the shared multiplier (sine polynomial, depth scale,
//  sample scale) and a rounding step; the right one loads the result register.
//  A finished pair waits in the result register; the next pair is taken
//  meanwhile and only its final write stalls until the result word leaves.
//  rst is synchronous: counter and phase clear, registers take defaults.
// ----------------------------------------------------------------------------
module stereo_sine_tremolo import sst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sst_in_if.sink    samples,
  sst_out_if.source results,
  sst_cfg_if.sink   cfg
);

  `include "assert_macros.svh"

  state_t state, state_next;

  logic [DEPTH_W-1:0] depth;
  logic [STEP_W-1:0]  phase_step;
  logic [OFFS_W-1:0]  right_phase_offset;

  logic [COUNT_W-1:0] sample_count;
  logic [STEP_W-1:0]  lfo_phase;

  logic signed [SAMPLE_W-1:0] left_smp, right_smp, left_res;
  logic signed [SAMPLE_W-1:0] out_left, out_right;
  logic                       out_valid;
  logic                       chan;
  logic                       neg;
  logic [15:0]                x;
  logic [16:0]                x2;
  logic signed [35:0]         prod;

  logic                       accept;
  logic                       load_out;
  logic [COUNT_W-1:0]         cnt_inc;
  logic                       wrap;

  logic [15:0]                 phase_r;
  logic [SINE_TABLE_BITS-1:0]  idx;
  logic [1:0]                  quad;
  logic [SINE_TABLE_BITS-3:0]  pos;
  logic [14:0]                 x_raw;
  logic [15:0]                 x_cur;
  logic [16:0]                 prod_q;
  logic [DEPTH_W-1:0]          d_sat;
  logic signed [17:0]          gain;
  logic signed [SAMPLE_W-1:0]  smp;
  logic signed [35:0]          p_rnd;
  logic signed [20:0]          r;
  logic signed [SAMPLE_W-1:0]  r_sat;
  logic signed [17:0]          mul_a, mul_b;

  assign accept   = samples.valid && samples.ready;
  assign load_out = (state == ST_RND) && chan && (!out_valid || results.ready);

  assign samples.ready     = (state == ST_IDLE);
  assign cfg.ready         = 1'b1;
  assign results.valid     = out_valid;
  assign results.left_out  = out_left;
  assign results.right_out = out_right;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (samples.valid) state_next = ST_SQ;
      ST_SQ:   state_next = ST_CX2;
      ST_CX2:  state_next = ST_T1;
      ST_T1:   state_next = ST_SIN;
      ST_SIN:  state_next = ST_DEP;
      ST_DEP:  state_next = ST_GAIN;
      ST_GAIN: state_next = ST_RND;
      ST_RND: begin
        if (!chan) begin
          state_next = ST_SQ;
        end else if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- angle for the current channel ----
  assign phase_r = lfo_phase[31:16] + right_phase_offset;
  assign idx     = chan ? phase_r[15 -: SINE_TABLE_BITS] : lfo_phase[31 -: SINE_TABLE_BITS];
  assign quad    = idx[SINE_TABLE_BITS-1 -: 2];
  assign pos     = idx[SINE_TABLE_BITS-3:0];
  assign x_raw   = 15'(pos) << (17 - SINE_TABLE_BITS);
  // odd quadrants run the angle backward
  assign x_cur   = quad[0] ? (16'd32768 - {1'b0, x_raw}) : {1'b0, x_raw};

  // ---- shared multiplier operands ----
  assign prod_q = prod[31:15];
  assign d_sat  = (depth > DEPTH_FULL) ? DEPTH_FULL : depth;
  assign gain   = neg ? (18'sd32768 + $signed({1'b0, prod_q}))
                      : (18'sd32768 - $signed({1'b0, prod_q}));
  assign smp    = chan ? right_smp : left_smp;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = $signed({2'b00, x_cur});
        mul_b = $signed({2'b00, x_cur});
      end
      ST_CX2: begin
        mul_a = $signed({1'b0, SIN_C});
        mul_b = $signed({1'b0, prod_q});
      end
      ST_T1: begin
        mul_a = $signed({1'b0, SIN_B - prod_q});
        mul_b = $signed({1'b0, x2});
      end
      ST_SIN: begin
        mul_a = $signed({1'b0, SIN_A - prod_q});
        mul_b = $signed({2'b00, x});
      end
      ST_DEP: begin
        mul_a = $signed({2'b00, d_sat});
        mul_b = $signed({1'b0, prod_q});
      end
      ST_GAIN: begin
        mul_a = 18'(smp);
        mul_b = gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---- round and saturate ----
  assign p_rnd = prod + 36'sd16384;
  assign r     = p_rnd[35:15];
  always_comb begin
    if (r > 21'sd32767) begin
      r_sat = 16'sh7FFF;
    end else if (r < -21'sd32768) begin
      r_sat = 16'sh8000;
    end else begin
      r_sat = r[15:0];
    end
  end

  // ---- counter and phase ----
  assign cnt_inc = sample_count + 1'b1;
  assign wrap    = (cnt_inc >= COUNT_W'(WRAP_COUNT)) || (cnt_inc == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      lfo_phase    <= '0;
    end else if (accept) begin
      if (wrap) begin
        sample_count <= '0;
        lfo_phase    <= '0;
      end else begin
        sample_count <= cnt_inc;
        lfo_phase    <= lfo_phase + phase_step;
      end
    end
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      depth              <= DEPTH_RESET;
      phase_step         <= STEP_RESET;
      right_phase_offset <= OFFS_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_DEPTH:        depth              <= cfg.data[DEPTH_W-1:0];
        REG_PHASE_STEP:   phase_step         <= cfg.data[STEP_W-1:0];
        REG_RIGHT_OFFSET: right_phase_offset <= cfg.data[OFFS_W-1:0];
        default:          ;  // drop writes past the register list
      endcase
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      chan      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        chan <= 1'b0;
      end else if (state == ST_RND && !chan) begin
        chan <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      left_smp  <= samples.left_in;
      right_smp <= samples.right_in;
    end
    if (state == ST_SQ) begin
      x   <= x_cur;
      neg <= quad[1];
    end
    if (state == ST_CX2) begin
      x2 <= prod_q;
    end
    if (state != ST_IDLE && state != ST_RND) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_RND && !chan) begin
      left_res <= r_sat;
    end
    if (load_out) begin
      out_left  <= left_res;
      out_right <= r_sat;
    end
  end

  // ---- assertions ----
  `ASSERT_CLK(a_accept_starts_left, accept |=> (state == ST_SQ && !chan),
    "accepted word did not start on the left channel")
  `ASSERT_CLK(a_result_from_right, $rose(out_valid) |-> $past(state == ST_RND && chan),
    "result word raised outside the right channel rounding step")
  `ASSERT_CLK(a_wrap_clears_phase, accept ##1 (sample_count == '0) |-> (lfo_phase == '0),
    "phase not cleared on counter wrap")
  `ASSERT_CLK(a_count_range, sample_count < COUNT_W'(WRAP_COUNT),
    "sample counter past wrap value")

endmodule

FILE: bench/stereo_sine_tremolo_tb.sv
// ----------------------------------------------------------------------------
// stereo_sine_tremolo_tb
// Self-checking bench for the stereo sine tremolo. Stereo pairs go in on the
// sample channel and register writes on the config channel. A bit-exact
// model of the counter, the phase accumulator, the polynomial sine and the
// gain stage predicts every result word. Both sides idle in random bursts,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module stereo_sine_tremolo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WRAP_SAMPLES = 8 * 44100;
  localparam int unsigned LFO_BITS     = 10;
  localparam longint unsigned POLY_A   = 51472;
  localparam longint unsigned POLY_B   = 21024;
  localparam longint unsigned POLY_C   = 2320;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam logic [sst_pkg::CFG_IDX_W-1:0] REG_NONE = '1;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } pair_t;

  logic clk;
  logic rst;

  sst_in_if  samples_if ();
  sst_out_if results_if ();
  sst_cfg_if cfg_if ();

  stereo_sine_tremolo dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if.sink),
    .results (results_if.source),
    .cfg     (cfg_if.sink)
  );

  // model state and registers
  logic [18:0] model_count  = '0;
  logic [31:0] model_phase  = '0;
  logic [15:0] model_depth  = 16'd16384;
  logic [31:0] model_step   = 32'd97392;
  logic [15:0] model_offset = 16'd0;

  pair_t       expected_pairs[$];
  int unsigned fail_count  = 0;
  int unsigned pairs_sent  = 0;
  int unsigned reg_writes  = 0;
  int unsigned pairs_seen  = 0;
  bit          idle_on     = 1'b1;
  int          hold_cycles = 0;

  // signed Q15 sine of the top table bits of the phase
  function automatic longint lfo_sine(input logic [31:0] ph);
    logic [LFO_BITS-1:0] idx;
    longint unsigned x, x2, t, s;
    idx = ph[31 -: LFO_BITS];
    x = idx[LFO_BITS-3:0];
    x = x << (17 - LFO_BITS);
    if (idx[LFO_BITS-2])
      x = 64'd32768 - x;
    x2 = (x * x) >> 15;
    t = POLY_B - ((POLY_C * x2) >> 15);
    t = POLY_A - ((t * x2) >> 15);
    s = (t * x) >> 15;
    return idx[LFO_BITS-1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic signed [15:0] tremolo_scale(input logic signed [15:0] smp,
                                                        input logic [31:0] ph);
    longint sn, d, mag, m, gain, p, r;
    sn = lfo_sine(ph);
    d = (model_depth > 16'd32768) ? 32768 : model_depth;
    mag = (sn < 0) ? -sn : sn;
    m = (d * mag) >>> 15;
    gain = (sn < 0) ? 32768 + m : 32768 - m;
    p = longint'(smp) * gain + 16384;
    r = p >>> 15;
    if (r > 32767)
      r = 32767;
    if (r < -32768)
      r = -32768;
    return r[15:0];
  endfunction

  function automatic pair_t tremolo_predict(input logic signed [15:0] l,
                                            input logic signed [15:0] r);
    pair_t res;
    model_count = model_count + 1'b1;
    if (model_count >= WRAP_SAMPLES || model_count == 0) begin
      model_count = '0;
      model_phase = '0;
    end else begin
      model_phase = model_phase + model_step;
    end
    res.left  = tremolo_scale(l, model_phase);
    res.right = tremolo_scale(r, model_phase + {model_offset, 16'h0000});
    return res;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus a long hold when requested
  initial begin
    int stall_left;
    stall_left = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        results_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        results_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pair_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      pairs_seen++;
      if (expected_pairs.size() == 0) begin
        $error("result word with nothing pending: left_out %0d right_out %0d",
               results_if.left_out, results_if.right_out);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (results_if.left_out !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, results_if.left_out);
          fail_count++;
        end
        if (results_if.right_out !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, results_if.right_out);
          fail_count++;
        end
      end
    end
  end

  // Leaves valid high on return; the next call keeps or drops it.
  task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r);
    cfg_if.valid <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    samples_if.valid    <= 1'b1;
    samples_if.left_in  <= l;
    samples_if.right_in <= r;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    expected_pairs.push_back(tremolo_predict(l, r));
    pairs_sent++;
  endtask

  // Write only once every pending word has come back.
  task automatic write_reg(input logic [sst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    samples_if.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      sst_pkg::REG_DEPTH:        model_depth  = value[15:0];
      sst_pkg::REG_PHASE_STEP:   model_step   = value;
      sst_pkg::REG_RIGHT_OFFSET: model_offset = value[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pair(pick_sample(), pick_sample());
  endtask

  task automatic test_default_settings();
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(-16'sd1, 16'sd1);
  endtask

  // quarter turn per sample lands on every quadrant edge: gain 0, 1 and 2
  task automatic test_full_depth_quadrants();
    write_reg(sst_pkg::REG_DEPTH, 32'd32768);
    write_reg(sst_pkg::REG_PHASE_STEP, 32'h4000_0000);
    write_reg(sst_pkg::REG_RIGHT_OFFSET, 32'h0000_4000);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh8000);
  endtask

  // depth above full clamps; upper data bits beyond the width drop
  task automatic test_depth_clamp_and_wide_data();
    write_reg(sst_pkg::REG_DEPTH, 32'hFFFF_FFFF);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh8000);
    write_reg(sst_pkg::REG_DEPTH, 32'h1234_4000);
    send_pair(16'sh7FFF, 16'sh8000);
  endtask

  task automatic test_step_and_offset_extremes();
    write_reg(sst_pkg::REG_DEPTH, 32'd0);
    write_reg(sst_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(sst_pkg::REG_RIGHT_OFFSET, 32'hABCD_FFFF);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(-16'sd1, 16'sd1);
    write_reg(sst_pkg::REG_DEPTH, 32'd32768);
    write_reg(sst_pkg::REG_PHASE_STEP, 32'd0);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    write_reg(sst_pkg::REG_RIGHT_OFFSET, 32'h0000_8000);
    send_pair(16'sh1234, -16'sd1234);
  endtask

  task automatic test_unknown_index();
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh4000, -16'sh4000);
  endtask

  task automatic test_random_settings();
    logic [15:0] dep;
    logic [31:0] stp;
    logic [15:0] off;
    repeat (6) begin
      case ($urandom_range(0, 4))
        0: dep = 16'd0;
        1: dep = 16'd32768;
        2: dep = 16'hFFFF;
        3: dep = 16'($urandom_range(32769, 65535));
        default: dep = 16'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 4))
        0: stp = 32'd0;
        1: stp = '1;
        2: stp = $urandom_range(0, 1 << 20);
        3: stp = $urandom;
        default: stp = $urandom_range(1 << 24, 1 << 28);
      endcase
      case ($urandom_range(0, 3))
        0: off = 16'h0000;
        1: off = 16'hFFFF;
        default: off = 16'($urandom);
      endcase
      write_reg(sst_pkg::REG_DEPTH, {16'($urandom), dep});
      write_reg(sst_pkg::REG_PHASE_STEP, stp);
      write_reg(sst_pkg::REG_RIGHT_OFFSET, {16'($urandom), off});
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_NONE, $urandom);
      send_random(60);
    end
  endtask

  // hold the result side while words keep coming, so the input stalls
  task automatic test_backpressure();
    write_reg(sst_pkg::REG_DEPTH, 32'd24576);
    write_reg(sst_pkg::REG_PHASE_STEP, 32'h0100_0000);
    idle_on = 1'b0;
    hold_cycles = HOLD_CYCLES;
    send_random(24);
    idle_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    write_reg(sst_pkg::REG_DEPTH, 32'd32768);
    write_reg(sst_pkg::REG_PHASE_STEP, $urandom_range(1 << 22, 1 << 27));
    write_reg(sst_pkg::REG_RIGHT_OFFSET, 32'h0000_4000);
    idle_on = 1'b0;
    send_random(40);
  endtask

  initial begin
    rst                 <= 1'b1;
    samples_if.valid    <= 1'b0;
    samples_if.left_in  <= '0;
    samples_if.right_in <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_full_depth_quadrants();
    test_depth_clamp_and_wide_data();
    test_step_and_offset_extremes();
    test_unknown_index();
    test_random_settings();
    test_backpressure();
    test_steady_stream();

    samples_if.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d stereo pairs and %0d register writes; %0d result words checked.",
             pairs_sent, reg_writes, pairs_seen);
    $display("Covered quadrant edges, depth clamp, wide and unknown writes, and a long hold.");
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
